// ----- sv/stsp_pkg.sv -----
// ----------------------------------------------------------------------------
// stsp_pkg
// shared types and constants for the shell token splitter
// ----------------------------------------------------------------------------
package stsp_pkg;

    localparam int COUNT_BITS  = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_SINGLE = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_OP   = 1'b1;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_PIPE   = 8'h7c;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       line_end;
    } char_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        token_start;
        logic        token_end;
        logic        token_kind;
        logic        line_done;
        logic [11:0] token_count;
    } tok_t;

    typedef struct packed {
        logic has_second;
        tok_t first_res;
        tok_t second_res;
    } step_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ----- sv/stsp_front.sv -----
// ----------------------------------------------------------------------------
// stsp_front
// classifies each byte, tracks quote and held-byte state, builds step records
// ----------------------------------------------------------------------------
module stsp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  stsp_pkg::char_t char_data,
    output logic           push,
    output stsp_pkg::step_t push_data
);
    import stsp_pkg::*;

    logic [7:0]            held_byte_reg, held_byte_next;
    logic                  held_valid_reg, held_valid_next;
    logic                  held_first_reg, held_first_next;
    logic                  held_kind_reg, held_kind_next;
    logic [1:0]            quote_reg, quote_next;
    logic                  pair_reg, pair_next;
    logic [COUNT_BITS-1:0] tokens_reg, tokens_next;

    logic [7:0] b;
    logic       le;
    logic       in_quote;
    logic       is_sep;
    logic       is_op;
    logic       kept;
    logic       cont;
    logic       kind;
    logic [7:0] closer;
    logic       a_en;
    logic       b_en;
    tok_t       res_a;
    tok_t       res_b;

    always_comb
    begin
        b        = char_data.in_byte;
        le       = char_data.line_end;
        in_quote = (quote_reg != QUOTE_NONE);
        closer   = (quote_reg == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
        is_sep   = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        is_op    = (b == CH_LT) || (b == CH_GT) || (b == CH_PIPE);
        kept     = in_quote || !is_sep;
        kind     = KIND_WORD;
        cont     = 1'b0;
        quote_next = quote_reg;
        pair_next  = 1'b0;

        if (in_quote)
        begin
            cont = held_valid_reg && (held_kind_reg == KIND_WORD);
            if (b == closer)
            begin
                quote_next = QUOTE_NONE;
            end
        end
        else if (is_sep)
        begin
            cont = 1'b0;
        end
        else if (is_op)
        begin
            kind      = KIND_OP;
            cont      = pair_reg && held_valid_reg && (held_kind_reg == KIND_OP)
                        && (held_byte_reg == b);
            pair_next = !cont && (b != CH_PIPE);
        end
        else
        begin
            cont = held_valid_reg && (held_kind_reg == KIND_WORD);
            if (b == CH_SQUOTE)
            begin
                quote_next = QUOTE_SINGLE;
            end
            else if (b == CH_DQUOTE)
            begin
                quote_next = QUOTE_DOUBLE;
            end
        end

        tokens_next = tokens_reg;
        if (kept && !cont && (tokens_reg != '1))
        begin
            tokens_next = tokens_reg + 1'b1;
        end

        // result for the byte held from the previous transaction
        a_en              = held_valid_reg;
        res_a.byte_valid  = 1'b1;
        res_a.out_byte    = held_byte_reg;
        res_a.token_start = held_first_reg;
        res_a.token_end   = kept ? !cont : 1'b1;
        res_a.token_kind  = held_kind_reg;
        res_a.line_done   = kept ? 1'b0 : le;
        res_a.token_count = 12'(tokens_reg);

        // line end: flush the new byte, or a bare end marker
        b_en              = le && (kept || !held_valid_reg);
        res_b.byte_valid  = kept;
        res_b.out_byte    = kept ? b : 8'h00;
        res_b.token_start = kept && !cont;
        res_b.token_end   = kept;
        res_b.token_kind  = kept && kind;
        res_b.line_done   = 1'b1;
        res_b.token_count = 12'(tokens_next);

        push                 = take && (a_en || b_en);
        push_data.has_second = a_en && b_en;
        push_data.first_res  = a_en ? res_a : res_b;
        push_data.second_res = res_b;

        if (kept)
        begin
            held_byte_next  = b;
            held_valid_next = 1'b1;
            held_first_next = !cont;
            held_kind_next  = kind;
        end
        else
        begin
            held_byte_next  = 8'h00;
            held_valid_next = 1'b0;
            held_first_next = 1'b0;
            held_kind_next  = KIND_WORD;
        end

        if (le)
        begin
            held_byte_next  = 8'h00;
            held_valid_next = 1'b0;
            held_first_next = 1'b0;
            held_kind_next  = KIND_WORD;
            quote_next      = QUOTE_NONE;
            pair_next       = 1'b0;
            tokens_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b0;
            held_kind_reg  <= KIND_WORD;
            quote_reg      <= QUOTE_NONE;
            pair_reg       <= 1'b0;
            tokens_reg     <= '0;
        end
        else if (take)
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            held_first_reg <= held_first_next;
            held_kind_reg  <= held_kind_next;
            quote_reg      <= quote_next;
            pair_reg       <= pair_next;
            tokens_reg     <= tokens_next;
        end
    end

endmodule

// ----- sv/stsp_queue.sv -----
// ----------------------------------------------------------------------------
// stsp_queue
// short fifo of step records between front and back
// ----------------------------------------------------------------------------
module stsp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stsp_pkg::step_t  push_data,
    input  logic             pop,
    output stsp_pkg::step_t  head,
    output stsp_pkg::qstat_t stat
);
    import stsp_pkg::*;

    step_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        head       = mem_reg[rd_ptr_reg];
        stat.full  = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
        stat.empty = (count_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/stsp_back.sv -----
// ----------------------------------------------------------------------------
// stsp_back
// unpacks step records into one result per transaction on the output register
// ----------------------------------------------------------------------------
module stsp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  stsp_pkg::step_t  head,
    input  stsp_pkg::qstat_t stat,
    output logic             pop,
    output logic             tok_valid,
    input  logic             tok_stall,
    output stsp_pkg::tok_t   tok_data
);
    import stsp_pkg::*;

    logic out_valid_reg, out_valid_next;
    tok_t out_reg, out_next;
    logic sub_reg, sub_next;
    logic load;

    always_comb
    begin
        load           = !out_valid_reg || !tok_stall;
        pop            = 1'b0;
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load)
        begin
            out_valid_next = !stat.empty;
            if (!stat.empty)
            begin
                out_next = sub_reg ? head.second_res : head.first_res;
                if (sub_reg || !head.has_second)
                begin
                    pop      = 1'b1;
                    sub_next = 1'b0;
                end
                else
                begin
                    sub_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign tok_valid = out_valid_reg;
    assign tok_data  = out_reg;

endmodule

// ----- sv/shell_token_splitter.sv -----
// ----------------------------------------------------------------------------
// shell_token_splitter
// streaming command line lexer: bytes in, token bytes with start/end marks out
// path: a byte's result passes through the step queue and the output register
//   once a later transaction releases it from the hold stage
// throughput: one byte per cycle while char_stall is low; a line end that
//   flushes two results is absorbed by the four-entry step queue
// reset: line state cleared, queue empty, no output transaction pending
// ----------------------------------------------------------------------------
module shell_token_splitter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             char_valid,
    output logic             char_stall,
    input  stsp_pkg::char_t  char_data,
    output logic             tok_valid,
    input  logic             tok_stall,
    output stsp_pkg::tok_t   tok_data
);
    import stsp_pkg::*;

    logic   take;
    logic   push;
    logic   pop;
    step_t  push_data;
    step_t  head;
    qstat_t q_stat;

    assign char_stall = q_stat.full;
    assign take       = char_valid && !char_stall;

    stsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .char_data (char_data),
        .push      (push),
        .push_data (push_data)
    );

    stsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    stsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (q_stat),
        .pop       (pop),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data)
    );

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !q_stat.empty)
        else $error("queue full and empty at once");

    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && !tok_data.byte_valid) |->
        (tok_data.line_done && !tok_data.token_start && !tok_data.token_end))
        else $error("bare end marker with token flags");

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && !tok_stall && tok_data.line_done) |=>
        (!tok_valid || (tok_data.token_count <= 12'd1)))
        else $error("token count not restarted after line end");

endmodule
